### rtl/mad_pkg.sv
// Package for the moving average deviation unit: widths, defaults and the control state type.
package mad_pkg;

   // Field widths fixed by the interface
   localparam int SAMPLE_W = 16;
   localparam int AVG_W    = 16;
   localparam int DEV_W    = 17;
   localparam int CSR_W    = 9;

   // Default store depth and register reset value
   localparam int          DEPTH_DEF     = 256;
   localparam logic [CSR_W-1:0] CSR_LEN_RESET = 9'd16;

   // Saturation limits of the average, as magnitudes
   localparam int AVG_POS_MAX = 32767;
   localparam int AVG_NEG_MAX = 32768;

   // Control sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } mad_state_type;

endpackage

### rtl/mad_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mad_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, read before write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mad_div.sv
// Bit-serial restoring divider: unsigned dividend by unsigned divisor, one quotient bit a cycle.
module mad_div #(
   parameter int SUM_W = 25,
   parameter int DIV_W = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             busy,
   output logic [SUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W:0]   rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;

   logic [DIV_W:0]   rem_shift;
   logic             fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_shift = {rem_ff[DIV_W-1:0], quo_ff[SUM_W-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
   end

   // Next values of the shift registers
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? (rem_shift - {1'b0, dvs_ff}) : rem_shift;
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   // A new division never starts on top of a running one
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   // The step counter is zero exactly when idle
   a_cnt_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (cnt_ff != '0))
      else $error("divider counter out of step with busy");

   // Remainder stays below the divisor while stepping
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !$past(start) |-> rem_ff < {1'b0, dvs_ff})
      else $error("divider remainder out of range");

endmodule

### rtl/moving_average_deviation_unit.sv
// A request is taken in the idle state; the load state folds it into the running sum and the store
// and starts the bit-serial divider; the divide state waits for it, and the finish state loads the
// response register. A new request is taken only in the idle state, so only once the last is finished.
// The response register frees the input side: a new request is taken while a result waits.
// Reset (synchronous, active high) clears sum, index, full flag and window length (16),
// then a clearing pass zeroes every slot of the sample store; req_ready stays low meanwhile.
// Window length writes are taken at any time, including during the clearing pass.
module moving_average_deviation_unit #(
   parameter int DEPTH = mad_pkg::DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [mad_pkg::CSR_W-1:0]          csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [mad_pkg::SAMPLE_W-1:0] req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [mad_pkg::AVG_W-1:0]   rsp_average,
   output logic signed [mad_pkg::DEV_W-1:0]   rsp_deviation
);

   import mad_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = SAMPLE_W + IDX_W + 1;
   localparam int CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   mad_state_type state_ff, state_in;

   logic [CSR_W-1:0]    win_len_ff, win_len_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                full_ff, full_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                neg_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0]    avg_ff, avg_in;
   logic [DEV_W-1:0]    dev_ff, dev_in;

   logic                req_fire;
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [SAMPLE_W-1:0] ram_wdata;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic                div_start;
   logic                div_busy;
   logic [SUM_W-1:0]    div_quo;
   logic                out_load;

   logic [CNT_W-1:0]    eff_len;
   logic [CNT_W-1:0]    count;
   logic [CNT_W-1:0]    divisor;
   logic [SUM_W-1:0]    sum_new;
   logic [SUM_W-1:0]    sum_mag;

   assign req_fire = req_valid && req_ready;

   // Window length register
   always_comb begin
      win_len_in = csr_wr_en ? csr_wr_data : win_len_ff;
   end

   // Effective window: zero means one, capped at the store depth
   always_comb begin
      if (win_len_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (CMP_W'(win_len_ff) > CMP_W'(DEPTH)) begin
         eff_len = CNT_W'(DEPTH);
      end else begin
         eff_len = CNT_W'(win_len_ff);
      end
   end

   // Running sum update and divisor choice
   always_comb begin
      count   = CNT_W'(idx_ff) + CNT_W'(1);
      divisor = full_ff ? eff_len : count;
      sum_new = sum_ff
              - {{(SUM_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata}
              + {{(SUM_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
      sum_mag = sum_new[SUM_W-1] ? (SUM_W'(0) - sum_new) : sum_new;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IDX_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!div_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = sample_ff;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_LOAD: begin
            ram_we    = 1'b1;
            div_start = 1'b1;
         end
         ST_DIVIDE: begin
         end
         ST_FINISH: begin
            out_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   // Sum, index and full flag move on when the item is folded in
   always_comb begin
      sum_in  = sum_ff;
      idx_in  = idx_ff;
      full_in = full_ff;
      clr_in  = clr_ff + IDX_W'(1);
      if (state_ff == ST_LOAD) begin
         sum_in = sum_new;
         if (count >= eff_len) begin
            idx_in  = '0;
            full_in = 1'b1;
         end else begin
            idx_in = IDX_W'(count);
         end
      end
   end

   // Sign fix, saturation and deviation of the finished quotient
   always_comb begin
      if (neg_ff) begin
         avg_in = (div_quo > SUM_W'(AVG_NEG_MAX)) ? AVG_W'(AVG_NEG_MAX)
                                                 : AVG_W'(0) - div_quo[AVG_W-1:0];
      end else begin
         avg_in = (div_quo > SUM_W'(AVG_POS_MAX)) ? AVG_W'(AVG_POS_MAX)
                                                 : div_quo[AVG_W-1:0];
      end
      dev_in = {sample_ff[SAMPLE_W-1], sample_ff} - {avg_in[AVG_W-1], avg_in};
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         win_len_ff   <= CSR_LEN_RESET;
         idx_ff       <= '0;
         full_ff      <= 1'b0;
         sum_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_len_ff   <= win_len_in;
         idx_ff       <= idx_in;
         full_ff      <= full_in;
         sum_ff       <= sum_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_sample;
      end
      if (div_start) begin
         neg_ff <= sum_new[SUM_W-1];
      end
      if (out_load) begin
         avg_ff <= avg_in;
         dev_ff <= dev_in;
      end
   end

   // Sample store
   mad_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // Serial divider for the average
   mad_div #(
      .SUM_W (SUM_W),
      .DIV_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_average   = avg_ff;
   assign rsp_deviation = dev_ff;

   // An accepted transaction always goes through the fold-in step
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_LOAD)
      else $error("accepted transaction did not reach load");

   // The divider only runs while the sequencer waits for it
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == ST_DIVIDE)
      else $error("divider busy outside divide state");

   // A new response appears only out of the finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside finish");

   // Index stays inside the store depth after each fold-in
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff) == ST_LOAD && !$past(reset) |-> CNT_W'(idx_ff) < CNT_W'(DEPTH))
      else $error("write index beyond store depth");

endmodule

### tb/mad_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the moving average deviation unit: window model, response queue, compare.
module mad_result_checker #(
   parameter int DEPTH = mad_pkg::DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mad_pkg::CSR_W-1:0]           csr_wr_data,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [mad_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [mad_pkg::AVG_W-1:0]    rsp_average,
   input  logic signed [mad_pkg::DEV_W-1:0]    rsp_deviation,
   output int                                  fail_count,
   output int                                  outstanding
);

   import mad_pkg::*;

   typedef struct packed {
      logic signed [AVG_W-1:0] average;
      logic signed [DEV_W-1:0] deviation;
   } avg_dev_type;

   // Shadow copy of the window state and the length register
   logic signed [SAMPLE_W-1:0] window_samples [DEPTH];
   longint                     window_sum;
   int unsigned                next_slot;
   bit                         window_filled;
   logic [CSR_W-1:0]           window_len;

   avg_dev_type pending_results [$];
   int          mismatches = 0;

   assign fail_count = mismatches;

   // Update the window with one sample and work out average and deviation
   task automatic compute_average(input logic signed [SAMPLE_W-1:0] sample,
                                  output avg_dev_type result);
      int unsigned span;
      int unsigned fill_count;
      longint      quotient;
      span = (window_len == '0) ? 1 : window_len;
      if (span > DEPTH) span = DEPTH;
      window_sum = window_sum - longint'(window_samples[next_slot]) + longint'(sample);
      window_samples[next_slot] = sample;
      fill_count = next_slot + 1;
      // divide by samples seen so far until the window has filled once
      if (window_filled) quotient = window_sum / longint'(span);
      else               quotient = window_sum / longint'(fill_count);
      // stale entries beyond a shrunk window can push the quotient out of range
      if (quotient > AVG_POS_MAX)       quotient = AVG_POS_MAX;
      else if (quotient < -AVG_NEG_MAX) quotient = -AVG_NEG_MAX;
      // a slot at or past the (possibly shrunk) length wraps the index
      if (fill_count >= span) begin
         next_slot     = 0;
         window_filled = 1'b1;
      end else begin
         next_slot = fill_count;
      end
      result.average   = quotient[AVG_W-1:0];
      result.deviation = DEV_W'(longint'(sample) - quotient);
   endtask

   // Watch both channels and the register port
   always @(posedge clock) begin : track
      avg_dev_type want;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) window_samples[i] = '0;
         window_sum    = 0;
         next_slot     = 0;
         window_filled = 1'b0;
         window_len    = CSR_LEN_RESET;
         pending_results.delete();
      end else begin
         if (csr_wr_en) window_len = csr_wr_data;
         // response first: it belongs to an earlier transaction
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response with no transaction pending: average %0d deviation %0d",
                        $time, rsp_average, rsp_deviation);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_average !== want.average) begin
                  $display("%0t: average mismatch: expected %0d, actual %0d",
                           $time, want.average, rsp_average);
                  mismatches++;
               end
               if (rsp_deviation !== want.deviation) begin
                  $display("%0t: deviation mismatch: expected %0d, actual %0d",
                           $time, want.deviation, rsp_deviation);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            compute_average(req_sample, want);
            pending_results.push_back(want);
         end
      end
      outstanding <= pending_results.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the moving average deviation unit: clock, reset, stimulus and verdict.
module tb;
   import mad_pkg::*;

   localparam int LATENCY        = 28;    // derived from the sum width at the default depth
   localparam int WATCHDOG_LIMIT = 4000;  // covers clearing pass and the long hold
   localparam int RANDOM_ITEMS   = 400;
   localparam int LONG_HOLD      = 300;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       csr_wr_en   = 1'b0;
   logic [CSR_W-1:0]           csr_wr_data = '0;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   logic signed [AVG_W-1:0]    rsp_average;
   logic signed [DEV_W-1:0]    rsp_deviation;

   int fail_count;
   int outstanding;
   int quiet_cycles = 0;
   bit no_idle      = 1'b0;
   bit hold_request = 1'b0;
   bit hold_taken   = 1'b0;

   always #2 clock = ~clock;

   moving_average_deviation_unit #(
      .DEPTH(DEPTH_DEF)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_average   (rsp_average),
      .rsp_deviation (rsp_deviation)
   );

   mad_result_checker #(
      .DEPTH(DEPTH_DEF)
   ) mad_check (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_average   (rsp_average),
      .rsp_deviation (rsp_deviation),
      .fail_count    (fail_count),
      .outstanding   (outstanding)
   );

   // Offer one sample, with an optional gap first; valid stays up between back-to-back items
   task automatic push_sample(input logic signed [SAMPLE_W-1:0] value);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drain the block, then write the window length
   task automatic write_window_len(input logic [CSR_W-1:0] len);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Receiver: random stall bursts, plus one long hold to back up the block
   initial begin
      @(posedge clock);
      forever begin
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** moving_average_deviation_unit: FAILED **");
         $finish;
      end
   end

   // Stimulus
   initial begin : stimulus
      int                         sent;
      int                         phase;
      int                         phase_items;
      int                         style;
      logic signed [SAMPLE_W-1:0] value;
      logic [CSR_W-1:0]           len;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // default window: field extremes and bit patterns
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      push_sample(16'sh0000);
      push_sample(16'shFFFF);
      push_sample(16'sh0001);
      push_sample(16'sh5555);
      // shrink below the write index: write there, then wrap
      write_window_len(9'd4);
      push_sample(16'shAAAA);
      push_sample(16'sh7FFF);
      // zero length acts as a window of one
      write_window_len(9'd0);
      push_sample(16'sh8000);
      push_sample(16'sh1234);
      // length above the store depth is capped
      write_window_len(9'h1FF);
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      // fill eight slots at full scale, then shrink to one: average saturates
      write_window_len(9'd8);
      repeat (8) push_sample(16'sh7FFF);
      write_window_len(9'd1);
      push_sample(16'sh7FFF);
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);

      // random phases, each with its own window length and sample mix
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= RANDOM_ITEMS - 70) no_idle = 1'b1;
         case ($urandom_range(0, 7))
            0:       len = '0;
            1:       len = 9'd1;
            2:       len = 9'd256;
            3:       len = 9'h1FF;
            4:       len = CSR_W'($urandom_range(257, 510));
            5:       len = CSR_W'($urandom_range(2, 8));
            default: len = CSR_W'($urandom_range(2, 255));
         endcase
         write_window_len(len);
         if (phase == 1) hold_request = 1'b1;
         phase_items = $urandom_range(20, 60);
         style       = $urandom_range(0, 4);
         repeat (phase_items) begin
            case (style)
               0:       value = ($urandom_range(0, 7) == 0) ? SAMPLE_W'($urandom) : 16'sh7FFF;
               1:       value = ($urandom_range(0, 7) == 0) ? SAMPLE_W'($urandom) : 16'sh8000;
               2:       value = SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
               default: begin
                  case ($urandom_range(0, 7))
                     0:       value = 16'sh7FFF;
                     1:       value = 16'sh8000;
                     2:       value = 16'sh0000;
                     3:       value = 16'shFFFF;
                     default: value = SAMPLE_W'($urandom);
                  endcase
               end
            endcase
            push_sample(value);
            sent++;
         end
         phase++;
      end
      req_valid <= 1'b0;

      // drain and let the pipeline settle
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("** moving_average_deviation_unit: PASSED **");
      end else begin
         $display("** moving_average_deviation_unit: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/mad_pkg.sv
rtl/mad_ram.sv
rtl/mad_div.sv
rtl/moving_average_deviation_unit.sv
tb/mad_result_checker.sv
tb/tb.sv
